// ----- rtl/pic_pkg.sv -----
// ----------------------------------------------------------------------------
// pic_pkg
// Types and constants shared by the pedigree inbreeding coefficient block.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned IdxW     = 12;
  localparam int unsigned Depth    = 4096;
  localparam int unsigned FracBits = 30;
  localparam int unsigned ValW     = 31;
  localparam int unsigned WgtW     = 32;
  localparam int unsigned SqW      = 34;
  localparam int unsigned PrW      = 35;
  localparam int unsigned AccW     = 48;

  localparam logic [ValW-1:0] FxOne = ValW'(1) << FracBits;
  localparam logic [IdxW-1:0] IdxMax = IdxW'(Depth - 1);

  typedef struct packed {
    logic [IdxW-1:0] dam_index;
    logic            dam_known;
    logic [IdxW-1:0] sire_index;
    logic            sire_known;
    logic [ValW-1:0] supplied_inbreeding;
    logic            last_animal;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] animal_number;
    logic [ValW-1:0] inbreeding;
    logic [ValW-1:0] sampling_variance;
    logic            order_error;
    logic            pedigree_end;
  } out_req_t;

  typedef struct packed {
    logic [IdxW-1:0] dam;
    logic [IdxW-1:0] sire;
    logic            dam_ok;
    logic            sire_ok;
  } parents_t;

  typedef struct packed {
    logic            en;
    logic            start;
    logic [IdxW-1:0] idx;
    parents_t        par;
    logic [ValW-1:0] dii;
  } walk_req_t;

  typedef struct packed {
    logic            ready;
    logic            done;
    logic [ValW-1:0] f;
  } walk_rsp_t;

endpackage

// ----- rtl/pic_walk.sv -----
// ----------------------------------------------------------------------------
// pic_walk
// Parent and variance stores plus path weight memory; ancestor walk engine.
// ----------------------------------------------------------------------------
module pic_walk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pic_pkg::walk_req_t req_i,
  output pic_pkg::walk_rsp_t rsp_o
);

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StSir  = 3'd4;
  localparam logic [2:0] StDrd  = 3'd5;
  localparam logic [2:0] StDam  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  pic_pkg::parents_t             par_mem [pic_pkg::Depth];
  logic [pic_pkg::ValW-1:0]      var_mem [pic_pkg::Depth];
  logic [pic_pkg::WgtW-1:0]      wgt_mem [pic_pkg::Depth];

  logic [2:0]                    state_q, state_d;
  logic [pic_pkg::IdxW-1:0]      j_q, j_d;
  logic [pic_pkg::WgtW-1:0]      w_q, w_d;
  pic_pkg::parents_t             p_q, p_d;
  logic [pic_pkg::ValW-1:0]      v_q, v_d;
  logic [pic_pkg::SqW-1:0]       sq_q, sq_d;
  logic [pic_pkg::PrW-1:0]       pr_q, pr_d;
  logic [pic_pkg::AccW-1:0]      acc_q, acc_d;
  logic [pic_pkg::ValW-1:0]      f_q, f_d;
  logic                          done_q, done_d;
  logic                          fwd_q;
  logic [pic_pkg::WgtW-1:0]      fwd_data_q;

  logic [pic_pkg::IdxW-1:0]      rd_addr;
  logic [pic_pkg::WgtW-1:0]      w_rd;
  logic [pic_pkg::WgtW-1:0]      w_eff;
  pic_pkg::parents_t             p_rd;
  logic [pic_pkg::ValW-1:0]      v_rd;
  logic                          w_we;
  logic [pic_pkg::IdxW-1:0]      w_addr;
  logic [pic_pkg::WgtW-1:0]      w_wdata;
  logic [pic_pkg::WgtW:0]        w_sum;
  logic [pic_pkg::WgtW-1:0]      w_sat;
  logic [63:0]                   sq_full;
  logic [64:0]                   pr_full;
  logic [pic_pkg::AccW:0]        acc_sum;
  logic [pic_pkg::AccW-1:0]      acc_m1;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      par_mem[req_i.idx] <= req_i.par;
      var_mem[req_i.idx] <= req_i.dii;
    end
    p_rd <= par_mem[rd_addr];
    v_rd <= var_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wgt_mem[w_addr] <= w_wdata;
    end
    w_rd       <= wgt_mem[rd_addr];
    fwd_q      <= w_we && (w_addr == rd_addr);
    fwd_data_q <= w_wdata;
  end

  assign w_eff   = fwd_q ? fwd_data_q : w_rd;
  assign w_sum   = {1'b0, w_eff} + {2'b0, w_q[pic_pkg::WgtW-1:1]};
  assign w_sat   = w_sum[pic_pkg::WgtW] ? '1 : w_sum[pic_pkg::WgtW-1:0];
  assign sq_full = 64'(w_eff) * 64'(w_eff) + (64'(1) << (pic_pkg::FracBits - 1));
  assign pr_full = 65'(sq_q) * 65'(v_q) + (65'(1) << (pic_pkg::FracBits - 1));
  assign acc_sum = {1'b0, acc_q} + (pic_pkg::AccW + 1)'(pr_q);
  assign acc_m1  = acc_q - pic_pkg::AccW'(pic_pkg::FxOne);

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    w_d     = w_q;
    p_d     = p_q;
    v_d     = v_q;
    sq_d    = sq_q;
    pr_d    = pr_q;
    acc_d   = acc_q;
    f_d     = f_q;
    done_d  = 1'b0;
    rd_addr = j_q;
    w_we    = 1'b0;
    w_addr  = j_q;
    w_wdata = '0;
    case (state_q)
      StClr: begin
        w_we = 1'b1;
        j_d  = j_q + 1'b1;
        if (j_q == pic_pkg::IdxMax) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_i.start) begin
          w_we    = 1'b1;
          w_addr  = req_i.idx;
          w_wdata = pic_pkg::WgtW'(pic_pkg::FxOne);
          j_d     = req_i.idx;
          acc_d   = '0;
          state_d = StRd;
        end
      end
      StRd: begin
        state_d = StChk;
      end
      StChk: begin
        w_d  = w_eff;
        p_d  = p_rd;
        v_d  = v_rd;
        sq_d = sq_full[63:pic_pkg::FracBits];
        if (w_eff == '0) begin
          rd_addr = j_q - 1'b1;
          j_d     = j_q - 1'b1;
          if (j_q == '0) begin
            state_d = StFin;
          end
        end else begin
          w_we    = 1'b1;
          rd_addr = p_rd.sire;
          state_d = StSir;
        end
      end
      StSir: begin
        pr_d    = pr_full[64:pic_pkg::FracBits];
        w_we    = p_q.sire_ok;
        w_addr  = p_q.sire;
        w_wdata = w_sat;
        state_d = StDrd;
      end
      StDrd: begin
        rd_addr = p_q.dam;
        acc_d   = acc_sum[pic_pkg::AccW] ? '1 : acc_sum[pic_pkg::AccW-1:0];
        state_d = StDam;
      end
      StDam: begin
        w_we    = p_q.dam_ok;
        w_addr  = p_q.dam;
        w_wdata = w_sat;
        rd_addr = j_q - 1'b1;
        j_d     = j_q - 1'b1;
        state_d = (j_q == '0) ? StFin : StChk;
      end
      StFin: begin
        if (acc_q <= pic_pkg::AccW'(pic_pkg::FxOne)) begin
          f_d = '0;
        end else if (acc_m1 > pic_pkg::AccW'(pic_pkg::FxOne)) begin
          f_d = pic_pkg::FxOne;
        end else begin
          f_d = acc_m1[pic_pkg::ValW-1:0];
        end
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    p_q   <= p_d;
    v_q   <= v_d;
    sq_q  <= sq_d;
    pr_q  <= pr_d;
    acc_q <= acc_d;
    f_q   <= f_d;
  end

  assign rsp_o.ready = (state_q == StIdle);
  assign rsp_o.done  = done_q;
  assign rsp_o.f     = f_q;

endmodule

// ----- rtl/pedigree_inbreeding_coefficients.sv -----
// ----------------------------------------------------------------------------
// pedigree_inbreeding_coefficients
// Numbers animals in pedigree order and gives inbreeding and sampling variance.
// ----------------------------------------------------------------------------
//   channel  valid        stall         payload
//   in       in_valid_i   in_stall_o    in_data_i  (pic_pkg::in_req_t)
//   out      out_valid_o  out_stall_i   out_data_o (pic_pkg::out_req_t)
//   cfg      cfg_we_i     -             cfg_wdata_i
// Supplied or sibling-copied values need no ancestor walk. A computed value
// waits on the downward scan of the path weight memory from the animal's own
// index, one entry per cycle for entries of zero weight; ancestors take longer.
// After reset a clearing pass zeroes the path weight memory.
// A result waiting under out_stall_i holds the block after its next request.
module pedigree_inbreeding_coefficients (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pic_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pic_pkg::out_req_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRdd  = 3'd1;
  localparam logic [2:0] StRds  = 3'd2;
  localparam logic [2:0] StCalc = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [pic_pkg::ValW-1:0]  f_mem [pic_pkg::Depth];

  logic [2:0]                state_q, state_d;
  logic                      supplied_q;
  logic [pic_pkg::IdxW-1:0]  cnt_q, cnt_d;
  pic_pkg::parents_t         par_q, par_d;
  pic_pkg::parents_t         prev_q, prev_d;
  logic [pic_pkg::ValW-1:0]  fprev_q, fprev_d;
  logic [pic_pkg::ValW-1:0]  sup_q, sup_d;
  logic                      last_q, last_d;
  logic                      err_q, err_d;
  logic [pic_pkg::ValW-1:0]  fd_q, fd_d;
  logic [pic_pkg::ValW-1:0]  f_q, f_d;
  logic [pic_pkg::ValW-1:0]  dii_q, dii_d;
  logic                      out_valid_q, out_valid_d;
  pic_pkg::out_req_t         out_q, out_d;

  logic [pic_pkg::IdxW-1:0]  f_raddr;
  logic [pic_pkg::ValW-1:0]  f_rd;
  logic                      f_we;
  logic                      accept;
  logic                      dam_ok, sire_ok;
  logic [pic_pkg::ValW+1:0]  num;
  logic                      sibling;
  pic_pkg::walk_req_t        walk_req;
  pic_pkg::walk_rsp_t        walk_rsp;

  pic_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (walk_req),
    .rsp_o  (walk_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      f_mem[cnt_q] <= f_q;
    end
    f_rd <= f_mem[f_raddr];
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = !((state_q == StIdle) && walk_rsp.ready);
  assign dam_ok     = in_data_i.dam_known && (in_data_i.dam_index < cnt_q);
  assign sire_ok    = in_data_i.sire_known && (in_data_i.sire_index < cnt_q);
  assign f_raddr    = (state_q == StRdd) ? par_q.dam : par_q.sire;

  always_comb begin
    num = (pic_pkg::ValW + 2)'(pic_pkg::FxOne) << 1;
    num = par_q.dam_ok ? num - (pic_pkg::ValW + 2)'(fd_q)
                       : num + (pic_pkg::ValW + 2)'(pic_pkg::FxOne);
    num = par_q.sire_ok ? num - (pic_pkg::ValW + 2)'(f_rd)
                        : num + (pic_pkg::ValW + 2)'(pic_pkg::FxOne);
  end

  assign sibling = (cnt_q != '0) && (par_q == prev_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    par_d       = par_q;
    prev_d      = prev_q;
    fprev_d     = fprev_q;
    sup_d       = sup_q;
    last_d      = last_q;
    err_d       = err_q;
    fd_d        = fd_q;
    f_d         = f_q;
    dii_d       = dii_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    f_we        = 1'b0;
    walk_req    = '0;
    walk_req.idx = cnt_q;
    walk_req.par = par_q;
    walk_req.dii = num[pic_pkg::ValW+1:2];
    case (state_q)
      StIdle: begin
        if (accept) begin
          par_d.dam_ok  = dam_ok;
          par_d.sire_ok = sire_ok;
          par_d.dam     = dam_ok ? in_data_i.dam_index : '0;
          par_d.sire    = sire_ok ? in_data_i.sire_index : '0;
          err_d   = (in_data_i.dam_known && !dam_ok) || (in_data_i.sire_known && !sire_ok);
          sup_d   = (in_data_i.supplied_inbreeding > pic_pkg::FxOne) ? pic_pkg::FxOne
                                                                     : in_data_i.supplied_inbreeding;
          last_d  = in_data_i.last_animal;
          state_d = StRdd;
        end
      end
      StRdd: begin
        state_d = StRds;
      end
      StRds: begin
        fd_d    = f_rd;
        state_d = StCalc;
      end
      StCalc: begin
        dii_d       = num[pic_pkg::ValW+1:2];
        walk_req.en = 1'b1;
        if (supplied_q) begin
          f_d     = sup_q;
          state_d = StDone;
        end else if (sibling) begin
          f_d     = fprev_q;
          state_d = StDone;
        end else begin
          walk_req.start = 1'b1;
          state_d        = StWait;
        end
      end
      StWait: begin
        if (walk_rsp.done) begin
          f_d     = walk_rsp.f;
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          f_we                    = 1'b1;
          out_valid_d             = 1'b1;
          out_d.animal_number     = cnt_q;
          out_d.inbreeding        = f_q;
          out_d.sampling_variance = dii_q;
          out_d.order_error       = err_q;
          out_d.pedigree_end      = last_q;
          prev_d                  = par_q;
          fprev_d                 = f_q;
          cnt_d   = (last_q || cnt_q == pic_pkg::IdxMax) ? '0 : cnt_q + 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      supplied_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        supplied_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    par_q   <= par_d;
    prev_q  <= prev_d;
    fprev_q <= fprev_d;
    sup_q   <= sup_d;
    last_q  <= last_d;
    err_q   <= err_d;
    fd_q    <= fd_d;
    f_q     <= f_d;
    dii_q   <= dii_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/pedigree_inbreeding_coefficients_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pedigree_inbreeding_coefficients_tb
// Feeds pedigrees in both coefficient modes and checks every result against a
// local ancestor-walk predictor: sibling copies, order errors, saturation,
// random idling on both sides, a long output hold.
// ----------------------------------------------------------------------------
module pedigree_inbreeding_coefficients_tb;

  localparam int unsigned WatchLimit = 30000;
  localparam logic [63:0] One64 = 64'd1 << pic_pkg::FracBits;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pic_pkg::in_req_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  pic_pkg::out_req_t out_data_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;

  pedigree_inbreeding_coefficients dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0]       f_mem [pic_pkg::Depth];
  logic [63:0]       dii_mem [pic_pkg::Depth];
  logic [63:0]       wgt_mem [pic_pkg::Depth];
  bit                pend_mem [pic_pkg::Depth];
  pic_pkg::parents_t par_mem [pic_pkg::Depth];
  int unsigned       next_animal = 0;
  bit                supplied_mode = 1'b0;

  initial begin
    for (int i = 0; i < pic_pkg::Depth; i++) wgt_mem[i] = '0;
  end

  pic_pkg::in_req_t  pending_animals[$];
  pic_pkg::out_req_t expected_results[$];

  int unsigned errors = 0, results_seen = 0, pedigrees_seen = 0, order_errs_seen = 0;
  bit          in_fire = 1'b0, out_fire = 1'b0;
  bit          quiet = 1'b0;
  int unsigned hold_reqs = 0;

  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (pic_pkg::FracBits - 1));
    if (p[127:94] != 0) return '1;
    return p[93:30];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] ancestor_walk(int unsigned k);
    logic [63:0]       acc, w;
    pic_pkg::parents_t p;
    acc = 0;
    wgt_mem[k] = One64;
    pend_mem[k] = 1'b1;
    for (int j = k; j >= 0; j--) begin
      if (pend_mem[j]) begin
        w = wgt_mem[j];
        p = par_mem[j];
        if (p.sire_ok && p.sire < j) begin
          wgt_mem[p.sire] = add_sat(wgt_mem[p.sire], w >> 1);
          pend_mem[p.sire] = 1'b1;
        end
        if (p.dam_ok && p.dam < j) begin
          wgt_mem[p.dam] = add_sat(wgt_mem[p.dam], w >> 1);
          pend_mem[p.dam] = 1'b1;
        end
        acc = add_sat(acc, mul_round(mul_round(w, w), dii_mem[j]));
        wgt_mem[j] = 0;
        pend_mem[j] = 1'b0;
      end
    end
    if (acc <= One64) return 0;
    acc -= One64;
    return (acc > One64) ? One64 : acc;
  endfunction

  function automatic pic_pkg::out_req_t score_animal(pic_pkg::in_req_t r);
    int unsigned       k;
    pic_pkg::parents_t p;
    bit                err;
    logic [63:0]       num, f;
    pic_pkg::out_req_t o;
    k = next_animal;
    err = 1'b0;
    p.dam = r.dam_index;
    p.dam_ok = r.dam_known;
    p.sire = r.sire_index;
    p.sire_ok = r.sire_known;
    if (p.dam_ok && p.dam >= k) begin p.dam_ok = 1'b0; err = 1'b1; end
    if (p.sire_ok && p.sire >= k) begin p.sire_ok = 1'b0; err = 1'b1; end
    if (!p.dam_ok) p.dam = '0;
    if (!p.sire_ok) p.sire = '0;
    num = 2 * One64;
    num = p.dam_ok ? num - f_mem[p.dam] : num + One64;
    num = p.sire_ok ? num - f_mem[p.sire] : num + One64;
    dii_mem[k] = num >> 2;
    par_mem[k] = p;
    if (supplied_mode) begin
      f = {33'd0, r.supplied_inbreeding};
      if (f > One64) f = One64;
    end else if (k > 0 && p == par_mem[k-1]) begin
      f = f_mem[k-1];
    end else begin
      f = ancestor_walk(k);
    end
    f_mem[k] = f;
    o.animal_number = k[pic_pkg::IdxW-1:0];
    o.inbreeding = f[pic_pkg::ValW-1:0];
    o.sampling_variance = dii_mem[k][pic_pkg::ValW-1:0];
    o.order_error = err;
    o.pedigree_end = r.last_animal;
    next_animal = (r.last_animal || k + 1 >= pic_pkg::Depth) ? 0 : k + 1;
    return o;
  endfunction

  function automatic int unsigned draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // accept, predict and check at the rising edge
  always @(posedge clk_i) begin
    pic_pkg::out_req_t e;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    out_fire <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && cfg_we_i) supplied_mode = cfg_wdata_i;
    if (rst_ni && in_valid_i && !in_stall_o) expected_results.push_back(score_animal(in_data_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_data_o.pedigree_end) pedigrees_seen++;
      if (out_data_o.order_error) order_errs_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result for animal %0d", out_data_o.animal_number);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.animal_number !== e.animal_number) begin
          $error("animal_number exp %0d got %0d", e.animal_number, out_data_o.animal_number);
          errors++;
        end
        if (out_data_o.inbreeding !== e.inbreeding) begin
          $error("inbreeding exp %h got %h", e.inbreeding, out_data_o.inbreeding);
          errors++;
        end
        if (out_data_o.sampling_variance !== e.sampling_variance) begin
          $error("sampling_variance exp %h got %h", e.sampling_variance,
                 out_data_o.sampling_variance);
          errors++;
        end
        if (out_data_o.order_error !== e.order_error) begin
          $error("order_error exp %0b got %0b", e.order_error, out_data_o.order_error);
          errors++;
        end
        if (out_data_o.pedigree_end !== e.pedigree_end) begin
          $error("pedigree_end exp %0b got %0b", e.pedigree_end, out_data_o.pedigree_end);
          errors++;
        end
      end
    end
  end

  // request driver
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    logic v;
    v = in_valid_i;
    if (in_fire) v = 1'b0;
    if (rst_ni && !v) begin
      if (send_gap > 0) send_gap--;
      else if (pending_animals.size() > 0) begin
        in_data_i <= pending_animals.pop_front();
        v = 1'b1;
        send_gap = draw_wait();
      end
    end
    in_valid_i <= v;
  end

  // result receiver
  int unsigned stall_left = 0, long_hold = 0, holds_taken = 0;
  always @(negedge clk_i) begin
    if (holds_taken != hold_reqs) begin
      holds_taken = hold_reqs;
      long_hold = 400;
    end
    if (out_fire) stall_left = draw_wait();
    if (long_hold > 0) begin
      long_hold--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [pic_pkg::ValW-1:0] draw_supplied();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return pic_pkg::FxOne;
      2: return pic_pkg::FxOne + pic_pkg::ValW'($urandom_range(1, 1000));
      3: return pic_pkg::ValW'($urandom);
      default: return pic_pkg::ValW'($urandom_range(0, 32'h4000_0000));
    endcase
  endfunction

  task automatic pick_parent(int unsigned k, int unsigned err_pct,
                             output logic [pic_pkg::IdxW-1:0] idx, output logic known);
    int unsigned roll, back;
    roll = $urandom_range(0, 99);
    if (roll < err_pct) begin
      known = 1'b1;
      idx = ($urandom_range(0, 3) == 0) ? pic_pkg::IdxMax
                                        : pic_pkg::IdxW'($urandom_range(k, pic_pkg::Depth - 1));
    end else if (k == 0 || roll < err_pct + 20) begin
      known = 1'b0;
      idx = pic_pkg::IdxW'($urandom);
    end else begin
      known = 1'b1;
      back = (k > 6) ? 6 : k - 1;
      idx = ($urandom_range(0, 1) == 0) ? pic_pkg::IdxW'(k - 1 - $urandom_range(0, back))
                                         : pic_pkg::IdxW'($urandom_range(0, k - 1));
    end
  endtask

  task automatic add_pedigree(int unsigned n, int unsigned err_pct);
    pic_pkg::in_req_t r, prev;
    int unsigned      k;
    prev = '0;
    for (int unsigned i = 0; i < n; i++) begin
      k = i % pic_pkg::Depth;
      r = '0;
      r.supplied_inbreeding = draw_supplied();
      if (k > 0 && $urandom_range(0, 99) < 20) begin
        r.dam_index = prev.dam_index;
        r.dam_known = prev.dam_known;
        r.sire_index = prev.sire_index;
        r.sire_known = prev.sire_known;
      end else begin
        pick_parent(k, err_pct, r.dam_index, r.dam_known);
        pick_parent(k, err_pct, r.sire_index, r.sire_known);
      end
      r.last_animal = (i == n - 1);
      pending_animals.push_back(r);
      prev = r;
    end
  endtask

  task automatic push_animal(int dam, bit dk, int sire, bit sk,
                             logic [pic_pkg::ValW-1:0] sup, bit last);
    pic_pkg::in_req_t r;
    r.dam_index = pic_pkg::IdxW'(dam);
    r.dam_known = dk;
    r.sire_index = pic_pkg::IdxW'(sire);
    r.sire_known = sk;
    r.supplied_inbreeding = sup;
    r.last_animal = last;
    pending_animals.push_back(r);
  endtask

  task automatic drain();
    while (pending_animals.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_mode(bit v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);

    // computed mode: unknowns, sibling copy, full-sib and selfed matings, bad order
    push_animal(0, 0, 0, 0, '0, 0);
    push_animal(4095, 0, 4095, 0, '1, 0);
    push_animal(0, 1, 1, 1, '0, 0);
    push_animal(0, 1, 1, 1, '0, 0);
    push_animal(2, 1, 3, 1, '0, 0);
    push_animal(4, 1, 4, 1, '0, 0);
    push_animal(6, 1, 4095, 1, '0, 0);
    push_animal(5, 1, 5, 1, '0, 0);
    push_animal(4095, 0, 7, 1, '0, 0);
    push_animal(8, 1, 7, 1, '0, 1);
    drain();
    write_mode(1'b1);
    push_animal(0, 0, 0, 0, '0, 0);
    push_animal(0, 1, 0, 0, pic_pkg::FxOne, 0);
    push_animal(0, 1, 0, 0, pic_pkg::FxOne + 1, 0);
    push_animal(1, 1, 2, 1, '1, 0);
    push_animal(4095, 1, 3, 1, 31'h2000_0000, 1);
    drain();

    write_mode(1'b0);
    hold_reqs++;
    add_pedigree(30, 5);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3) write_mode(1'b1);
      if (ph == 4) write_mode(1'b0);
      if (ph == 5) quiet = 1'b1;
      for (int p = 0; p < 8; p++) add_pedigree($urandom_range(2, 12), 6);
      if (ph == 2) add_pedigree(200, 3);
      drain();
      quiet = 1'b0;
    end

    $display("checked %0d results in %0d pedigrees, %0d with order errors;",
             results_seen, pedigrees_seen, order_errs_seen);
    $display("both coefficient modes, sibling copies, saturation and long holds exercised");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pic_pkg.sv
rtl/pic_walk.sv
rtl/pedigree_inbreeding_coefficients.sv
tb/pedigree_inbreeding_coefficients_tb.sv
